// ===== design/login_keepalive_sequencer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Login keepalive sequencer assertion macros
// Shared concurrent assertion wrappers for the sequencer checkers.
// ----------------------------------------------------------------------------
`ifndef LOGIN_KEEPALIVE_SEQUENCER_UNIT_DEFINES_SVH
`define LOGIN_KEEPALIVE_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LKS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lks assertion failed");

// next-cycle implication, disabled during reset
`define LKS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lks assertion failed");

`endif

// ===== design/lks_pkg.sv =====
// ----------------------------------------------------------------------------
// Login keepalive sequencer package
// Widths, codes, register layout and shared state types.
// ----------------------------------------------------------------------------
package lks_pkg;

  localparam int TimerWidth = 8;
  localparam int RetryWidth = 4;
  localparam int AddrWidth  = 5;
  localparam int DataWidth  = 32;

  localparam logic [TimerWidth-1:0] TmrMax = '1;
  localparam logic [RetryWidth-1:0] RtyMax = '1;

  // sequencer states
  localparam logic [2:0] StIdle      = 3'd0;
  localparam logic [2:0] StAuth      = 3'd1;
  localparam logic [2:0] StAuthWait  = 3'd2;
  localparam logic [2:0] StHb        = 3'd3;
  localparam logic [2:0] StHbWait    = 3'd4;
  localparam logic [2:0] StReady     = 3'd5;
  localparam logic [2:0] StReadyWait = 3'd6;
  localparam logic [2:0] StConfirm   = 3'd7;

  // messages sent
  localparam logic [2:0] MsgNone    = 3'd0;
  localparam logic [2:0] MsgAuth    = 3'd1;
  localparam logic [2:0] MsgHb      = 3'd2;
  localparam logic [2:0] MsgReady   = 3'd3;
  localparam logic [2:0] MsgConfirm = 3'd4;

  // item operations
  localparam logic [2:0] OpTick      = 3'd0;
  localparam logic [2:0] OpAuthResp  = 3'd1;
  localparam logic [2:0] OpHbResp    = 3'd2;
  localparam logic [2:0] OpReadyAck  = 3'd3;
  localparam logic [2:0] OpReadyReq  = 3'd4;
  localparam logic [2:0] OpTravReq   = 3'd5;

  // register indexes (byte address 4*index)
  localparam logic [2:0] RegPlatformReady = 3'd0;
  localparam logic [2:0] RegAuthTimeout   = 3'd1;
  localparam logic [2:0] RegAuthLimit     = 3'd2;
  localparam logic [2:0] RegHbTimeout     = 3'd3;
  localparam logic [2:0] RegHbLimit       = 3'd4;
  localparam logic [2:0] RegReadyTimeout  = 3'd5;
  localparam logic [2:0] RegReadyLimit    = 3'd6;

  typedef struct packed {
    logic       platform_ready;
    logic [7:0] auth_timeout;
    logic [3:0] auth_limit;
    logic [7:0] hb_timeout;
    logic [3:0] hb_limit;
    logic [7:0] rdy_timeout;
    logic [3:0] rdy_limit;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    platform_ready: 1'b0,
    auth_timeout:   8'd5,
    auth_limit:     4'd3,
    hb_timeout:     8'd30,
    hb_limit:       4'd3,
    rdy_timeout:    8'd5,
    rdy_limit:      4'd3
  };

  typedef struct packed {
    logic [2:0]            seq;
    logic [TimerWidth-1:0] elapsed;
    logic [RetryWidth-1:0] auth_rty;
    logic [RetryWidth-1:0] hb_rty;
    logic [RetryWidth-1:0] rdy_rty;
    logic                  auth_seen;
    logic                  hb_seen;
    logic                  rdy_seen;
    logic [31:0]           stored_ip;
    logic [15:0]           stored_port;
    logic                  stored_valid;
    logic [31:0]           latest_ip;
    logic [15:0]           latest_port;
  } state_t;

  localparam state_t StateReset = '{
    seq:          StAuth,
    elapsed:      '0,
    auth_rty:     '0,
    hb_rty:       '0,
    rdy_rty:      '0,
    auth_seen:    1'b0,
    hb_seen:      1'b0,
    rdy_seen:     1'b0,
    stored_ip:    '0,
    stored_port:  '0,
    stored_valid: 1'b0,
    latest_ip:    '0,
    latest_port:  '0
  };

  typedef struct packed {
    logic [2:0] sent_message;
    logic [2:0] state_code;
    logic       login_failed;
    logic       address_changed;
  } res_t;

endpackage

// ===== design/login_keepalive_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// Login keepalive sequencer unit
// Client login and keepalive sequencer: ticks and received events in, one
// result per item out (message sent, state, failure and address flags).
// ----------------------------------------------------------------------------
//   channel | handshake                 | payload
//   --------+---------------------------+-------------------------------------
//   in      | in_valid_i / in_stall_o   | operation, reported_ip/port, peer
//   out     | out_valid_o / out_stall_i | sent_message, state_code, flags
//   cfg     | APB psel/penable/pready   | seven registers at 4*index
//
// One item per cycle sustained while the output is not stalled; a result is
// offered once its item passes the input register, then the result register.
// The state update for an item happens as it moves into the result register.
// No clearing pass: the block takes items from the first cycle after reset.
// A stalled output holds its result; the input register still fills behind it.
// ----------------------------------------------------------------------------
module login_keepalive_sequencer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    operation_i,
  input  logic [31:0]                   reported_ip_i,
  input  logic [15:0]                   reported_port_i,
  input  logic                          peer_ready_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    sent_message_o,
  output logic [2:0]                    state_code_o,
  output logic                          login_failed_o,
  output logic                          address_changed_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lks_pkg::AddrWidth-1:0] paddr,
  input  logic [lks_pkg::DataWidth-1:0] pwdata,
  output logic [lks_pkg::DataWidth-1:0] prdata,
  output logic                          pready
);

  lks_pkg::cfg_t   cfg;
  lks_pkg::state_t st_q;
  lks_pkg::state_t st_d;
  lks_pkg::res_t   res_d;
  lks_pkg::res_t   res_q;

  logic        s1_valid_q;
  logic [2:0]  s1_op_q;
  logic [31:0] s1_ip_q;
  logic [15:0] s1_port_q;
  logic        s1_peer_q;
  logic        out_valid_q;

  logic out_ready;
  logic s1_ready;
  logic s1_fire;
  logic in_take;

  lks_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || out_ready;
  assign s1_fire    = s1_valid_q && out_ready;
  assign in_take    = in_valid_i && s1_ready;
  assign in_stall_o = !s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_op_q   <= operation_i;
      s1_ip_q   <= reported_ip_i;
      s1_port_q <= reported_port_i;
      s1_peer_q <= peer_ready_i;
    end
  end

  lks_step u_step (
    .st_i            (st_q),
    .cfg_i           (cfg),
    .operation_i     (s1_op_q),
    .reported_ip_i   (s1_ip_q),
    .reported_port_i (s1_port_q),
    .peer_ready_i    (s1_peer_q),
    .st_o            (st_d),
    .res_o           (res_d)
  );

  // commit sequencer state as the item leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= lks_pkg::StateReset;
    end else if (s1_fire) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign sent_message_o    = res_q.sent_message;
  assign state_code_o      = res_q.state_code;
  assign login_failed_o    = res_q.login_failed;
  assign address_changed_o = res_q.address_changed;

endmodule

// ===== design/lks_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Login keepalive sequencer configuration registers
// APB register file holding timeouts, retry limits and the platform enable.
// ----------------------------------------------------------------------------
module lks_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lks_pkg::AddrWidth-1:0] paddr,
  input  logic [lks_pkg::DataWidth-1:0] pwdata,
  output logic [lks_pkg::DataWidth-1:0] prdata,
  output logic                         pready,
  output lks_pkg::cfg_t                cfg_o
);

  lks_pkg::cfg_t cfg_q;
  lks_pkg::cfg_t cfg_d;
  logic [2:0]    reg_idx;
  logic          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[lks_pkg::AddrWidth-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        lks_pkg::RegPlatformReady: cfg_d.platform_ready = pwdata[0];
        lks_pkg::RegAuthTimeout:   cfg_d.auth_timeout   = pwdata[7:0];
        lks_pkg::RegAuthLimit:     cfg_d.auth_limit     = pwdata[3:0];
        lks_pkg::RegHbTimeout:     cfg_d.hb_timeout     = pwdata[7:0];
        lks_pkg::RegHbLimit:       cfg_d.hb_limit       = pwdata[3:0];
        lks_pkg::RegReadyTimeout:  cfg_d.rdy_timeout    = pwdata[7:0];
        lks_pkg::RegReadyLimit:    cfg_d.rdy_limit      = pwdata[3:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= lks_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      lks_pkg::RegPlatformReady: prdata = 32'(cfg_q.platform_ready);
      lks_pkg::RegAuthTimeout:   prdata = 32'(cfg_q.auth_timeout);
      lks_pkg::RegAuthLimit:     prdata = 32'(cfg_q.auth_limit);
      lks_pkg::RegHbTimeout:     prdata = 32'(cfg_q.hb_timeout);
      lks_pkg::RegHbLimit:       prdata = 32'(cfg_q.hb_limit);
      lks_pkg::RegReadyTimeout:  prdata = 32'(cfg_q.rdy_timeout);
      lks_pkg::RegReadyLimit:    prdata = 32'(cfg_q.rdy_limit);
      default:                   prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/lks_step.sv =====
// ----------------------------------------------------------------------------
// Login keepalive sequencer step logic
// Next state and result for one item, given the current state and config.
// ----------------------------------------------------------------------------
module lks_step (
  input  lks_pkg::state_t st_i,
  input  lks_pkg::cfg_t   cfg_i,
  input  logic [2:0]      operation_i,
  input  logic [31:0]     reported_ip_i,
  input  logic [15:0]     reported_port_i,
  input  logic            peer_ready_i,
  output lks_pkg::state_t st_o,
  output lks_pkg::res_t   res_o
);

  logic [lks_pkg::TimerWidth-1:0] el_inc;
  logic [7:0]                     cur_timeout;
  logic                           wait_end;

  // saturating tick count for whichever wait state is active
  assign el_inc = (st_i.elapsed == lks_pkg::TmrMax) ? lks_pkg::TmrMax
                                                     : st_i.elapsed + 1'b1;

  always_comb begin
    unique case (st_i.seq)
      lks_pkg::StAuthWait:  cur_timeout = cfg_i.auth_timeout;
      lks_pkg::StHbWait:    cur_timeout = cfg_i.hb_timeout;
      default:              cur_timeout = cfg_i.rdy_timeout;
    endcase
  end

  assign wait_end = (32'(el_inc) >= 32'(cur_timeout)) || (el_inc == lks_pkg::TmrMax);

  always_comb begin
    st_o                  = st_i;
    res_o.sent_message    = lks_pkg::MsgNone;
    res_o.login_failed    = 1'b0;
    res_o.address_changed = 1'b0;

    unique case (operation_i)
      lks_pkg::OpTick: begin
        if (cfg_i.platform_ready) begin
          unique case (st_i.seq)
            lks_pkg::StIdle, lks_pkg::StAuth: begin
              if (st_i.seq == lks_pkg::StIdle) begin
                st_o.auth_rty = '0;
              end
              st_o.auth_seen     = 1'b0;
              res_o.sent_message = lks_pkg::MsgAuth;
              st_o.seq           = lks_pkg::StAuthWait;
              st_o.elapsed       = '0;
            end
            lks_pkg::StAuthWait: begin
              st_o.elapsed = el_inc;
              if (wait_end) begin
                if (!st_i.auth_seen) begin
                  st_o.auth_rty = (st_i.auth_rty == lks_pkg::RtyMax) ? lks_pkg::RtyMax
                                                                      : st_i.auth_rty + 1'b1;
                  st_o.seq      = lks_pkg::StAuth;
                end else begin
                  st_o.seq    = lks_pkg::StHb;
                  st_o.hb_rty = '0;
                end
                if (32'(st_o.auth_rty) == 32'(cfg_i.auth_limit)) begin
                  st_o.auth_rty      = '0;
                  st_o.seq           = lks_pkg::StIdle;
                  res_o.login_failed = 1'b1;
                end
              end
            end
            lks_pkg::StHb: begin
              st_o.hb_seen       = 1'b0;
              res_o.sent_message = lks_pkg::MsgHb;
              st_o.seq           = lks_pkg::StHbWait;
              st_o.elapsed       = '0;
            end
            lks_pkg::StHbWait: begin
              st_o.elapsed = el_inc;
              if (wait_end) begin
                priority if (!st_i.hb_seen) begin
                  st_o.hb_rty = (st_i.hb_rty == lks_pkg::RtyMax) ? lks_pkg::RtyMax
                                                                  : st_i.hb_rty + 1'b1;
                  st_o.seq    = lks_pkg::StHb;
                end else if (!st_i.stored_valid) begin
                  st_o.stored_ip    = st_i.latest_ip;
                  st_o.stored_port  = st_i.latest_port;
                  st_o.stored_valid = 1'b1;
                  st_o.seq          = lks_pkg::StHb;
                end else if (st_i.stored_ip != st_i.latest_ip
                             || st_i.stored_port != st_i.latest_port) begin
                  st_o.stored_ip        = st_i.latest_ip;
                  st_o.stored_port      = st_i.latest_port;
                  res_o.address_changed = 1'b1;
                end else begin
                  st_o.seq = lks_pkg::StHb;
                end
                // an address change skips the retry check and relogs at once
                if (res_o.address_changed) begin
                  st_o.seq = lks_pkg::StAuth;
                end else if (32'(st_o.hb_rty) == 32'(cfg_i.hb_limit)) begin
                  st_o.hb_rty = '0;
                  st_o.seq    = lks_pkg::StAuth;
                end
              end
            end
            lks_pkg::StReady: begin
              st_o.rdy_seen      = 1'b0;
              res_o.sent_message = lks_pkg::MsgReady;
              st_o.seq           = lks_pkg::StReadyWait;
              st_o.elapsed       = '0;
            end
            lks_pkg::StReadyWait: begin
              st_o.elapsed = el_inc;
              if (wait_end) begin
                if (!st_i.rdy_seen) begin
                  st_o.rdy_rty = (st_i.rdy_rty == lks_pkg::RtyMax) ? lks_pkg::RtyMax
                                                                    : st_i.rdy_rty + 1'b1;
                  st_o.seq     = lks_pkg::StReady;
                end else begin
                  st_o.seq = lks_pkg::StHb;
                end
                if (32'(st_o.rdy_rty) == 32'(cfg_i.rdy_limit)) begin
                  st_o.rdy_rty = '0;
                  st_o.seq     = lks_pkg::StHb;
                end
              end
            end
            default: begin
              res_o.sent_message = lks_pkg::MsgConfirm;
              st_o.seq           = lks_pkg::StHb;
            end
          endcase
        end
      end
      lks_pkg::OpAuthResp: st_o.auth_seen = 1'b1;
      lks_pkg::OpHbResp: begin
        st_o.hb_seen     = 1'b1;
        st_o.latest_ip   = reported_ip_i;
        st_o.latest_port = reported_port_i;
      end
      lks_pkg::OpReadyAck: st_o.rdy_seen = 1'b1;
      lks_pkg::OpReadyReq: st_o.seq = lks_pkg::StReady;
      lks_pkg::OpTravReq: begin
        if (peer_ready_i) begin
          st_o.seq = lks_pkg::StConfirm;
        end
      end
      default: st_o = st_i;
    endcase

    res_o.state_code = st_o.seq;
  end

endmodule

// ===== design/lks_checker.sv =====
// ----------------------------------------------------------------------------
// Login keepalive sequencer checker
// Port-level assertions on result consistency and output handshake.
// ----------------------------------------------------------------------------
`include "login_keepalive_sequencer_unit_defines.svh"

module lks_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] sent_message_o,
  input logic [2:0] state_code_o,
  input logic       login_failed_o,
  input logic       address_changed_o
);

  `LKS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(sent_message_o) && $stable(state_code_o))

  `LKS_ASSERT_SAME(a_fail_idle, clk_i, rst_ni, out_valid_o && login_failed_o, state_code_o == lks_pkg::StIdle && sent_message_o == lks_pkg::MsgNone && !address_changed_o)

  `LKS_ASSERT_SAME(a_change_relogin, clk_i, rst_ni, out_valid_o && address_changed_o, state_code_o == lks_pkg::StAuth && sent_message_o == lks_pkg::MsgNone)

  `LKS_ASSERT_SAME(a_msg_state, clk_i, rst_ni, out_valid_o && sent_message_o != lks_pkg::MsgNone, (sent_message_o == lks_pkg::MsgAuth && state_code_o == lks_pkg::StAuthWait) || (sent_message_o == lks_pkg::MsgHb && state_code_o == lks_pkg::StHbWait) || (sent_message_o == lks_pkg::MsgReady && state_code_o == lks_pkg::StReadyWait) || (sent_message_o == lks_pkg::MsgConfirm && state_code_o == lks_pkg::StHb))

endmodule

bind login_keepalive_sequencer_unit lks_checker u_lks_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .sent_message_o    (sent_message_o),
  .state_code_o      (state_code_o),
  .login_failed_o    (login_failed_o),
  .address_changed_o (address_changed_o)
);

// ===== bench/tb_login_keepalive_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// Login keepalive sequencer testbench
// Runs ticks and server events through the sequencer and checks every result
// against an in-bench prediction of the login, heartbeat, ready and confirm
// flow: directed paths first, then retry saturation, randomized server
// sessions under several register settings, and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_login_keepalive_sequencer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OpUnknownLo   = 3'd6;
  localparam logic [2:0] OpUnknownHi   = 3'd7;
  localparam int         HoldOffCycles = 150;
  localparam int         IdleLimit     = 3000;

  logic        clk             = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_stall_o;
  logic [2:0]  operation       = lks_pkg::OpTick;
  logic [31:0] reported_ip     = '0;
  logic [15:0] reported_port   = '0;
  logic        peer_ready      = 1'b0;
  logic        out_valid_o;
  logic        out_stall       = 1'b0;
  logic [2:0]  sent_message_o;
  logic [2:0]  state_code_o;
  logic        login_failed_o;
  logic        address_changed_o;
  logic        psel            = 1'b0;
  logic        penable         = 1'b0;
  logic        pwrite          = 1'b0;
  logic [lks_pkg::AddrWidth-1:0] paddr  = '0;
  logic [lks_pkg::DataWidth-1:0] pwdata = '0;
  logic [lks_pkg::DataWidth-1:0] prdata;
  logic        pready;

  // predicted sequencer state and register copy
  lks_pkg::state_t shadow_state = lks_pkg::StateReset;
  lks_pkg::cfg_t   shadow_cfg   = lks_pkg::CfgReset;
  lks_pkg::res_t   awaited_results[$];

  logic [31:0] server_ip    = 32'hC0A8_0001;
  logic [15:0] server_port  = 16'd5000;
  logic        gaps_on      = 1'b1;
  logic        stall_on     = 1'b1;
  logic        hold_start   = 1'b0;
  int          hold_left    = 0;
  int          stall_run    = 0;
  logic        stall_level  = 1'b0;
  int          error_count  = 0;
  int          results_seen = 0;
  int          idle_cycles  = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  login_keepalive_sequencer_unit uut (
    .clk_i             (clk),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall_o),
    .operation_i       (operation),
    .reported_ip_i     (reported_ip),
    .reported_port_i   (reported_port),
    .peer_ready_i      (peer_ready),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall),
    .sent_message_o    (sent_message_o),
    .state_code_o      (state_code_o),
    .login_failed_o    (login_failed_o),
    .address_changed_o (address_changed_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic logic [lks_pkg::RetryWidth-1:0] bump_retry(
      input logic [lks_pkg::RetryWidth-1:0] v);
    return (v == lks_pkg::RtyMax) ? v : v + 1'b1;
  endfunction

  // advance the wait timer; high once the wait is over
  function automatic logic wait_over(input logic [lks_pkg::TimerWidth-1:0] limit);
    if (shadow_state.elapsed != lks_pkg::TmrMax)
      shadow_state.elapsed = shadow_state.elapsed + 1'b1;
    return (shadow_state.elapsed >= limit) || (shadow_state.elapsed == lks_pkg::TmrMax);
  endfunction

  function automatic lks_pkg::res_t sequencer_step(input logic [2:0] op,
                                                   input logic [31:0] ip,
                                                   input logic [15:0] port,
                                                   input logic peer);
    lks_pkg::res_t r;
    logic moved_on_change;
    r = '0;
    r.sent_message = lks_pkg::MsgNone;
    moved_on_change = 1'b0;
    case (op)
      lks_pkg::OpTick: if (shadow_cfg.platform_ready) begin
        case (shadow_state.seq)
          lks_pkg::StIdle, lks_pkg::StAuth: begin
            if (shadow_state.seq == lks_pkg::StIdle) shadow_state.auth_rty = '0;
            shadow_state.auth_seen = 1'b0;
            r.sent_message = lks_pkg::MsgAuth;
            shadow_state.seq = lks_pkg::StAuthWait;
            shadow_state.elapsed = '0;
          end
          lks_pkg::StAuthWait: if (wait_over(shadow_cfg.auth_timeout)) begin
            if (!shadow_state.auth_seen) begin
              shadow_state.auth_rty = bump_retry(shadow_state.auth_rty);
              shadow_state.seq = lks_pkg::StAuth;
            end else begin
              shadow_state.seq = lks_pkg::StHb;
              shadow_state.hb_rty = '0;
            end
            if (shadow_state.auth_rty == shadow_cfg.auth_limit) begin
              shadow_state.auth_rty = '0;
              shadow_state.seq = lks_pkg::StIdle;
              r.login_failed = 1'b1;
            end
          end
          lks_pkg::StHb: begin
            shadow_state.hb_seen = 1'b0;
            r.sent_message = lks_pkg::MsgHb;
            shadow_state.seq = lks_pkg::StHbWait;
            shadow_state.elapsed = '0;
          end
          lks_pkg::StHbWait: if (wait_over(shadow_cfg.hb_timeout)) begin
            if (!shadow_state.hb_seen) begin
              shadow_state.hb_rty = bump_retry(shadow_state.hb_rty);
              shadow_state.seq = lks_pkg::StHb;
            end else if (!shadow_state.stored_valid) begin
              shadow_state.stored_ip = shadow_state.latest_ip;
              shadow_state.stored_port = shadow_state.latest_port;
              shadow_state.stored_valid = 1'b1;
              shadow_state.seq = lks_pkg::StHb;
            end else if (shadow_state.stored_ip != shadow_state.latest_ip ||
                         shadow_state.stored_port != shadow_state.latest_port) begin
              shadow_state.stored_ip = shadow_state.latest_ip;
              shadow_state.stored_port = shadow_state.latest_port;
              shadow_state.seq = lks_pkg::StAuth;
              r.address_changed = 1'b1;
              moved_on_change = 1'b1;
            end else begin
              shadow_state.seq = lks_pkg::StHb;
            end
            // an address change skips the heartbeat limit check
            if (!moved_on_change && shadow_state.hb_rty == shadow_cfg.hb_limit) begin
              shadow_state.hb_rty = '0;
              shadow_state.seq = lks_pkg::StAuth;
            end
          end
          lks_pkg::StReady: begin
            shadow_state.rdy_seen = 1'b0;
            r.sent_message = lks_pkg::MsgReady;
            shadow_state.seq = lks_pkg::StReadyWait;
            shadow_state.elapsed = '0;
          end
          lks_pkg::StReadyWait: if (wait_over(shadow_cfg.rdy_timeout)) begin
            if (!shadow_state.rdy_seen) begin
              shadow_state.rdy_rty = bump_retry(shadow_state.rdy_rty);
              shadow_state.seq = lks_pkg::StReady;
            end else begin
              shadow_state.seq = lks_pkg::StHb;
            end
            if (shadow_state.rdy_rty == shadow_cfg.rdy_limit) begin
              shadow_state.rdy_rty = '0;
              shadow_state.seq = lks_pkg::StHb;
            end
          end
          default: begin
            r.sent_message = lks_pkg::MsgConfirm;
            shadow_state.seq = lks_pkg::StHb;
          end
        endcase
      end
      lks_pkg::OpAuthResp: shadow_state.auth_seen = 1'b1;
      lks_pkg::OpHbResp: begin
        shadow_state.hb_seen = 1'b1;
        shadow_state.latest_ip = ip;
        shadow_state.latest_port = port;
      end
      lks_pkg::OpReadyAck: shadow_state.rdy_seen = 1'b1;
      lks_pkg::OpReadyReq: shadow_state.seq = lks_pkg::StReady;
      lks_pkg::OpTravReq: if (peer) shadow_state.seq = lks_pkg::StConfirm;
      default: ;
    endcase
    r.state_code = shadow_state.seq;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int roll;
    if (!gaps_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(input logic [2:0] op, input logic [31:0] ip,
                           input logic [15:0] port, input logic peer);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    operation     <= op;
    reported_ip   <= ip;
    reported_port <= port;
    peer_ready    <= peer;
    do @(posedge clk); while (in_stall_o);
    awaited_results.push_back(sequencer_step(op, ip, port, peer));
  endtask

  task automatic send_tick();
    send_item(lks_pkg::OpTick, $urandom, 16'($urandom), 1'($urandom));
  endtask

  // play the server side: mostly timely replies, some silence, some noise
  task automatic send_random_item();
    logic [2:0]  op;
    logic [31:0] ip;
    logic [15:0] port;
    logic        peer;
    int          roll;
    roll = $urandom_range(0, 99);
    ip   = $urandom;
    port = 16'($urandom);
    peer = 1'($urandom);
    op   = lks_pkg::OpTick;
    if (roll < 4) begin
      op = $urandom_range(0, 1) ? OpUnknownHi : OpUnknownLo;
    end else if (roll < 8) begin
      op = 3'($urandom_range(lks_pkg::OpAuthResp, lks_pkg::OpTravReq));
    end else begin
      case (shadow_state.seq)
        lks_pkg::StAuthWait: if (roll < 30) op = lks_pkg::OpAuthResp;
        lks_pkg::StHbWait: if (roll < 30) begin
          op = lks_pkg::OpHbResp;
          // move the external address now and then
          if (roll < 12) begin
            server_ip   = $urandom;
            server_port = 16'($urandom);
          end
          ip   = server_ip;
          port = server_port;
        end
        lks_pkg::StReadyWait: if (roll < 30) op = lks_pkg::OpReadyAck;
        lks_pkg::StHb: begin
          if (roll < 14) op = lks_pkg::OpReadyReq;
          else if (roll < 20) op = lks_pkg::OpTravReq;
        end
        default: ;
      endcase
    end
    send_item(op, ip, port, peer);
  endtask

  // drop valid and wait for every outstanding result
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx,
                           input logic [lks_pkg::DataWidth-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      lks_pkg::RegPlatformReady: shadow_cfg.platform_ready = value[0];
      lks_pkg::RegAuthTimeout:   shadow_cfg.auth_timeout   = value[7:0];
      lks_pkg::RegAuthLimit:     shadow_cfg.auth_limit     = value[3:0];
      lks_pkg::RegHbTimeout:     shadow_cfg.hb_timeout     = value[7:0];
      lks_pkg::RegHbLimit:       shadow_cfg.hb_limit       = value[3:0];
      lks_pkg::RegReadyTimeout:  shadow_cfg.rdy_timeout    = value[7:0];
      lks_pkg::RegReadyLimit:    shadow_cfg.rdy_limit      = value[3:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic pr, input logic [7:0] at, input logic [3:0] al,
                              input logic [7:0] ht, input logic [3:0] hl,
                              input logic [7:0] rt, input logic [3:0] rl);
    wait_idle();
    write_reg(lks_pkg::RegPlatformReady, {31'd0, pr});
    write_reg(lks_pkg::RegAuthTimeout,   {24'd0, at});
    write_reg(lks_pkg::RegAuthLimit,     {28'd0, al});
    write_reg(lks_pkg::RegHbTimeout,     {24'd0, ht});
    write_reg(lks_pkg::RegHbLimit,       {28'd0, hl});
    write_reg(lks_pkg::RegReadyTimeout,  {24'd0, rt});
    write_reg(lks_pkg::RegReadyLimit,    {28'd0, rl});
  endtask

  // random receiver stalls, plus one long hold-off on request
  always @(negedge clk) begin : drive_out_stall
    int roll;
    if (hold_start) begin
      hold_left  = HoldOffCycles;
      hold_start = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (!stall_on) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_run == 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
          stall_level = 1'b0;
          stall_run   = $urandom_range(1, 8);
        end else if (roll < 92) begin
          stall_level = 1'b1;
          stall_run   = $urandom_range(1, 3);
        end else begin
          stall_level = 1'b1;
          stall_run   = $urandom_range(8, 40);
        end
      end
      stall_run = stall_run - 1;
      out_stall <= stall_level;
    end
  end

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin : check_results
    lks_pkg::res_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result, state", int'(state_code_o), 0);
      end else begin
        want = awaited_results.pop_front();
        if (sent_message_o !== want.sent_message)
          report_mismatch("sent_message", int'(sent_message_o), int'(want.sent_message));
        if (state_code_o !== want.state_code)
          report_mismatch("state_code", int'(state_code_o), int'(want.state_code));
        if (login_failed_o !== want.login_failed)
          report_mismatch("login_failed", int'(login_failed_o), int'(want.login_failed));
        if (address_changed_o !== want.address_changed)
          report_mismatch("address_changed", int'(address_changed_o),
                          int'(want.address_changed));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
          (psel && penable && pwrite))
        idle_cycles = 0;
      else
        idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no handshake for %0d cycles", IdleLimit);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed_paths();
    // not ready yet: ticks do nothing, events still land
    send_item(lks_pkg::OpTick, '0, '0, 1'b0);
    send_item(OpUnknownLo, '1, '1, 1'b1);
    send_item(OpUnknownHi, '0, '0, 1'b0);
    send_item(lks_pkg::OpTravReq, '1, '1, 1'b0);
    send_item(lks_pkg::OpHbResp, '1, '1, 1'b1);
    send_item(lks_pkg::OpHbResp, '0, '0, 1'b0);
    send_item(lks_pkg::OpReadyAck, '0, '0, 1'b0);
    send_item(lks_pkg::OpAuthResp, '1, '1, 1'b1);
    program_regs(1'b1, 8'd1, 4'd1, 8'd1, 4'd2, 8'd1, 4'd1);
    // auth fails once -> idle, then login again
    send_tick();
    send_tick();
    send_tick();
    send_item(lks_pkg::OpAuthResp, '0, '0, 1'b0);
    send_tick();
    // first heartbeat stores the address, second one sees it change
    send_tick();
    send_item(lks_pkg::OpHbResp, '1, '1, 1'b0);
    send_tick();
    send_tick();
    send_item(lks_pkg::OpHbResp, 32'h0A00_0001, 16'd0, 1'b0);
    send_tick();
    // ready without ack, then a traversal confirm
    send_item(lks_pkg::OpReadyReq, '0, '0, 1'b0);
    send_tick();
    send_tick();
    send_item(lks_pkg::OpTravReq, '0, '0, 1'b1);
    send_tick();
    // two missed heartbeats force relogin
    send_tick();
    send_tick();
    send_tick();
    send_tick();
  endtask

  task automatic test_retry_saturation();
    // zero limits never trip: counters pin at their maximum
    program_regs(1'b1, 8'd1, 4'd0, 8'd1, 4'd0, 8'd1, 4'd0);
    repeat (40) send_tick();
    send_item(lks_pkg::OpReadyReq, '0, '0, 1'b0);
    repeat (40) send_tick();
    program_regs(1'b1, 8'd1, 4'd0, 8'd1, 4'd0, 8'd1, 4'd15);
    repeat (40) send_tick();
    program_regs(1'b1, 8'd1, 4'd15, 8'd1, 4'd15, 8'd1, 4'd15);
    repeat (6) send_tick();
  endtask

  task automatic test_random_sessions();
    int phase;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: program_regs(1'b1, 8'd1, 4'd1, 8'd1, 4'd1, 8'd1, 4'd1);
        1: program_regs(1'b1, 8'($urandom_range(1, 6)), 4'($urandom_range(1, 15)),
                        8'($urandom_range(1, 6)), 4'($urandom_range(1, 15)),
                        8'($urandom_range(1, 6)), 4'($urandom_range(1, 15)));
        2: program_regs(1'b1, 8'd255, 4'd15, 8'd255, 4'd15, 8'd255, 4'd15);
        3: program_regs(1'b0, 8'($urandom_range(1, 4)), 4'($urandom_range(1, 15)),
                        8'($urandom_range(1, 4)), 4'($urandom_range(1, 15)),
                        8'($urandom_range(1, 4)), 4'($urandom_range(1, 15)));
        4: program_regs(1'b1, 8'($urandom_range(1, 12)), 4'($urandom_range(1, 4)),
                        8'($urandom_range(1, 12)), 4'($urandom_range(1, 4)),
                        8'($urandom_range(1, 12)), 4'($urandom_range(1, 4)));
        default: program_regs(1'b1, 8'($urandom_range(1, 255)), 4'($urandom_range(1, 15)),
                              8'($urandom_range(1, 255)), 4'($urandom_range(1, 15)),
                              8'($urandom_range(1, 255)), 4'($urandom_range(1, 15)));
      endcase
      // one phase runs at full rate with no stalls
      gaps_on  = (phase != 1);
      stall_on = (phase != 1);
      repeat (300) send_random_item();
    end
    gaps_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    program_regs(1'b1, 8'd2, 4'd3, 8'd2, 4'd3, 8'd2, 4'd3);
    gaps_on    = 1'b0;
    hold_start = 1'b1;
    repeat (120) send_random_item();
    gaps_on    = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    test_directed_paths();
    test_retry_saturation();
    test_random_sessions();
    test_output_backpressure();
    wait_idle();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== login_keepalive_sequencer_unit.f =====
+incdir+design
design/lks_pkg.sv
design/lks_cfg_regs.sv
design/lks_step.sv
design/login_keepalive_sequencer_unit.sv
design/lks_checker.sv
bench/tb_login_keepalive_sequencer_unit.sv
